### hw/rtl/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
// No dependencies; used by every module of the block.
package iee_pkg;

    localparam int DATA_W = 32;

    // Operator codes on s_next_operator; codes above OP_END act as the end mark
    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        MOP_NONE = 2'd0,
        MOP_MUL  = 2'd1,
        MOP_DIV  = 2'd2
    } mop_t;

    // Result of the multiplier or divider, valid for one cycle with done
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] value;
        logic              clamped;
        logic              zero_div;
    } unit_res_t;

endpackage

### hw/rtl/iee_multiplier.sv
// Fixed-point multiplier: registered 32x32 product, then floor shift and clamp.
// Depends on iee_pkg.
module iee_multiplier import iee_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output unit_res_t                res
);

    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       done_reg;
    logic signed [2*DATA_W-1:0] shifted;
    logic                       hi_same;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= (2*DATA_W)'(a) * (2*DATA_W)'(b);
        end
    end

    // arithmetic shift floors toward minus infinity
    assign shifted = prod_reg >>> FRAC_BITS;
    assign hi_same = (&shifted[2*DATA_W-1:DATA_W-1]) || !(|shifted[2*DATA_W-1:DATA_W-1]);

    always_comb begin
        res.done     = done_reg;
        res.zero_div = 1'b0;
        res.clamped  = !hi_same;
        if (hi_same) begin
            res.value = shifted[DATA_W-1:0];
        end else if (shifted[2*DATA_W-1]) begin
            res.value = SAT_MIN;
        end else begin
            res.value = SAT_MAX;
        end
    end

endmodule

### hw/rtl/iee_divider.sv
// Restoring radix-2 divider for Q-format operands, one quotient bit per cycle.
// Depends on iee_pkg.
module iee_divider import iee_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output unit_res_t                res
);

    localparam int DW  = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]     dvd_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] ub_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DATA_W-1:0] value_reg;
    logic              clamped_reg;
    logic              zero_div_reg;

    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_diff;
    logic              ge;
    logic              pos_ovf;
    logic              neg_ovf;
    logic [DATA_W-1:0] q_lo;

    assign ua = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    assign ub = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);

    assign rem_sh   = {rem_reg, dvd_reg[DW-1]};
    assign rem_diff = rem_sh - {1'b0, ub_reg};
    assign ge       = !rem_diff[DATA_W];

    // quotient magnitude limits: 2^31-1 positive, 2^31 negative
    assign q_lo    = dvd_reg[DATA_W-1:0];
    assign pos_ovf = |dvd_reg[DW-1:DATA_W-1];
    assign neg_ovf = (|dvd_reg[DW-1:DATA_W]) || (q_lo[DATA_W-1] && |q_lo[DATA_W-2:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start && b != '0) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
            fin_reg  <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            // zero divisor answers without the loop, otherwise in the cycle after the last bit
            done_reg <= start ? (b == '0) : fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= {ua, {FRAC_BITS{1'b0}}};
            ub_reg  <= ub;
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            if (b == '0) begin
                zero_div_reg <= 1'b1;
                clamped_reg  <= 1'b0;
                value_reg    <= a[DATA_W-1] ? SAT_MIN : SAT_MAX;
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], ge};
        end else if (fin_reg) begin
            zero_div_reg <= 1'b0;
            if (!neg_reg) begin
                clamped_reg <= pos_ovf;
                value_reg   <= pos_ovf ? SAT_MAX : q_lo;
            end else begin
                clamped_reg <= neg_ovf;
                value_reg   <= neg_ovf ? SAT_MIN : DATA_W'(-q_lo);
            end
        end
    end

    always_comb begin
        res.done     = done_reg;
        res.value    = value_reg;
        res.clamped  = clamped_reg;
        res.zero_div = zero_div_reg;
    end

endmodule

### hw/rtl/infix_expression_evaluator_core.sv
// Infix expression evaluator, top level: sequencer, accumulator and result register.
// Depends on iee_pkg, iee_multiplier and iee_divider.
//
// Each input beat carries one signed fixed-point operand (FRAC_BITS fraction
// bits) and the operator that follows it: plus, minus, multiply, divide, or
// end (codes 5 to 7 also mean end). Multiply and divide bind tighter than
// plus and minus; equal levels associate to the left. One result beat
// leaves at each end mark, carrying the saturated value and sticky flags for
// a zero divisor and for any clamp, after which the state returns to reset.
// Each beat then takes one of three paths: straight to the accumulate step
// when no product is pending, through the multiplier (registered product,
// then shift and clamp) when a multiplication completes, or through the
// restoring divider, which resolves one of its 32 + FRAC_BITS quotient bits
// per cycle, when a division completes. A zero divisor skips the divider
// loop. s_ready is low while a beat is in work. A finished result sits in
// an output register, so the next expression may start while it waits; an
// end mark stalls only if that register is still full.
module infix_expression_evaluator_core import iee_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_operand,
    input  logic [2:0]               s_next_operator,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_value,
    output logic                     m_divided_by_zero,
    output logic                     m_saturated
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_ACC  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;

    // expression state
    logic [DATA_W-1:0] running_sum_reg;
    logic [DATA_W-1:0] product_term_reg;
    mop_t              pending_reg;
    logic              pending_minus_reg;
    logic              zero_div_seen_reg;
    logic              clamp_seen_reg;

    // current beat
    logic [2:0]        op_reg;
    logic [DATA_W-1:0] term_reg;

    // result register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic              m_dz_reg;
    logic              m_sat_reg;

    logic              accept;
    logic              mul_start;
    logic              div_start;
    unit_res_t         mul_res;
    unit_res_t         div_res;
    logic              is_mulop;
    logic              is_addop;
    logic              out_free;
    logic              out_load;
    logic [DATA_W:0]   sum_wide;
    logic              sum_clamp;
    logic [DATA_W-1:0] sum_val;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign mul_start = accept && (pending_reg == MOP_MUL);
    assign div_start = accept && (pending_reg == MOP_DIV);

    iee_multiplier #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (product_term_reg),
        .b       (s_operand),
        .res     (mul_res)
    );

    iee_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (product_term_reg),
        .b       (s_operand),
        .res     (div_res)
    );

    assign is_mulop = (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign is_addop = (op_reg == OP_PLUS) || (op_reg == OP_MINUS);
    assign out_free = !m_valid_reg || m_ready;
    // end mark finishing: result register takes the new beat
    assign out_load = (state_reg == ST_ACC) && !is_mulop && !is_addop && out_free;

    // 33-bit sum/difference; overflow when the top two bits differ
    assign sum_wide  = pending_minus_reg
                     ? {running_sum_reg[DATA_W-1], running_sum_reg} - {term_reg[DATA_W-1], term_reg}
                     : {running_sum_reg[DATA_W-1], running_sum_reg} + {term_reg[DATA_W-1], term_reg};
    assign sum_clamp = sum_wide[DATA_W] ^ sum_wide[DATA_W-1];
    assign sum_val   = sum_clamp ? (sum_wide[DATA_W] ? SAT_MIN : SAT_MAX) : sum_wide[DATA_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (pending_reg)
                        MOP_MUL: state_next = ST_MUL;
                        MOP_DIV: state_next = ST_DIV;
                        default: state_next = ST_ACC;
                    endcase
                end
            end
            ST_MUL: begin
                if (mul_res.done) begin
                    state_next = ST_ACC;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                // end mark waits here until the result register is free
                if (is_mulop || is_addop || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            running_sum_reg   <= '0;
            product_term_reg  <= '0;
            pending_reg       <= MOP_NONE;
            pending_minus_reg <= 1'b0;
            zero_div_seen_reg <= 1'b0;
            clamp_seen_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_MUL: begin
                    if (mul_res.done) begin
                        clamp_seen_reg <= clamp_seen_reg | mul_res.clamped;
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        clamp_seen_reg    <= clamp_seen_reg | div_res.clamped;
                        zero_div_seen_reg <= zero_div_seen_reg | div_res.zero_div;
                    end
                end
                ST_ACC: begin
                    if (is_mulop) begin
                        product_term_reg <= term_reg;
                        pending_reg      <= (op_reg == OP_MUL) ? MOP_MUL : MOP_DIV;
                    end else if (is_addop) begin
                        running_sum_reg   <= sum_val;
                        clamp_seen_reg    <= clamp_seen_reg | sum_clamp;
                        product_term_reg  <= '0;
                        pending_reg       <= MOP_NONE;
                        pending_minus_reg <= (op_reg == OP_MINUS);
                    end else if (out_free) begin
                        running_sum_reg   <= '0;
                        product_term_reg  <= '0;
                        pending_reg       <= MOP_NONE;
                        pending_minus_reg <= 1'b0;
                        zero_div_seen_reg <= 1'b0;
                        clamp_seen_reg    <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= s_next_operator;
            if (pending_reg == MOP_NONE) begin
                term_reg <= s_operand;
            end
        end else if (state_reg == ST_MUL && mul_res.done) begin
            term_reg <= mul_res.value;
        end else if (state_reg == ST_DIV && div_res.done) begin
            term_reg <= div_res.value;
        end
        if (out_load) begin
            m_value_reg <= sum_val;
            m_dz_reg    <= zero_div_seen_reg;
            m_sat_reg   <= clamp_seen_reg | sum_clamp;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_value           = m_value_reg;
    assign m_divided_by_zero = m_dz_reg;
    assign m_saturated       = m_sat_reg;

endmodule
